### rtl/core/tpmlf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpmlf_pkg: shared types and constants of the two-port MAC learning forwarder
// Table geometry, register indexes, decision codes and the slot hash.
// ----------------------------------------------------------------------------
package tpmlf_pkg;

  // Table geometry; the slot hash keeps the low index bits, so the entry
  // count is a power of two.
  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned LEN_W   = 14;
  localparam int unsigned PORT_W  = 2;
  localparam int unsigned CFG_W   = 48;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0]  HOST_BUFFER_BYTES = LEN_W'(2048);
  localparam logic [TIME_W-1:0] AGE_LIMIT_RESET   = 48'd300000000000;
  localparam logic [MAC_W-1:0]  MAC_BROADCAST     = '1;

  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned OUT_DATA_W = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORWARDING = 2'd0,
    CFG_AGE_LIMIT  = 2'd1,
    CFG_PORTS      = 2'd2
  } cfg_idx_e;

  // Forwarding decision codes
  typedef enum logic [2:0] {
    DEC_FLOOD_MCAST   = 3'd0,
    DEC_FLOOD_UNKNOWN = 3'd1,
    DEC_KNOWN         = 3'd2,
    DEC_SAME_PORT     = 3'd3,
    DEC_FWD_OFF       = 3'd4,
    DEC_HOST_MISS     = 3'd5
  } dec_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DEC
  } state_e;

  // One table entry as held in the memory
  typedef struct packed {
    logic [MAC_W-1:0]  addr;
    logic              port;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // Times-33 hash over the six address bytes, first transmitted byte first
  function automatic logic [IDX_W-1:0] slot_of(input logic [MAC_W-1:0] mac);
    logic [31:0] h;
    h = '0;
    for (int i = 5; i >= 0; i--) begin
      h = (h << 5) + h + 32'(mac[8*i +: 8]);
    end
    return h[IDX_W-1:0];
  endfunction

  // Group bit of the first byte, or all ones
  function automatic logic is_group(input logic [MAC_W-1:0] mac);
    return mac[40] || (mac == MAC_BROADCAST);
  endfunction

endpackage
`default_nettype wire

### rtl/core/two_port_mac_learning_forwarder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_port_mac_learning_forwarder_unit: learning bridge table for two PHYs
// Takes one frame header per request and returns its forwarding verdict.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one frame header per request (source port, destination
//   and source MAC, length, time). m_axis returns one verdict per header:
//   egress mask, host delivery, decision code, learned and aged-out flags.
//   The cfg port writes forwarding enable, age limit and attached ports. It
//   is to be written only while no header is in flight; the unit does not enforce this.
// Sequence:
//   A header passes the states accept, learn write plus table read, entry
//   compare and age check, decision. The table is one single-port-write,
//   registered-read memory that is read once and written at most once per
//   header; a new header is accepted only after the last has left its decision state.
// Reset:
//   All table entries become invalid at once (flip-flop valid bits); the
//   registers take their reset values. No clearing pass is needed.
// Stall:
//   A verdict waits in the output register; the next header is still
//   accepted and processed, and holds in its decision cycle until the
//   output register frees up.
// ----------------------------------------------------------------------------
module two_port_mac_learning_forwarder_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // [1:0] source_port, [49:2] dest_mac, [97:50] src_mac,
  // [111:98] frame_length, [159:112] now_time
  input  wire logic [tpmlf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // [1:0] egress_mask, [2] to_host, [5:3] decision, [6] learned, [7] aged_out
  output      logic [tpmlf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_we_i,
  input  wire logic [tpmlf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [tpmlf_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned IDX_W  = tpmlf_pkg::IDX_W;
  localparam int unsigned MAC_W  = tpmlf_pkg::MAC_W;
  localparam int unsigned TIME_W = tpmlf_pkg::TIME_W;
  localparam int unsigned LEN_W  = tpmlf_pkg::LEN_W;

  // Configuration registers
  logic              fwd_en_q;
  logic [TIME_W-1:0] age_limit_q;
  logic [1:0]        ports_q;

  // Sequencer
  tpmlf_pkg::state_e state_q, state_d;

  // Captured header
  logic [1:0]        sport_q;
  logic [MAC_W-1:0]  dmac_q;
  logic [MAC_W-1:0]  smac_q;
  logic [LEN_W-1:0]  flen_q;
  logic [TIME_W-1:0] now_q;
  logic [IDX_W-1:0]  slot_s_q;
  logic [IDX_W-1:0]  slot_d_q;
  logic              phy_q;
  logic              group_q;

  // Table storage
  logic                  valid_q [tpmlf_pkg::TABLE_ENTRIES];
  tpmlf_pkg::entry_t     mem_q   [tpmlf_pkg::TABLE_ENTRIES];
  tpmlf_pkg::entry_t     rd_q;
  tpmlf_pkg::entry_t     ent;
  tpmlf_pkg::entry_t     wr_entry;
  logic                  same_slot_q;

  // Compare results
  logic              match_q;
  logic              stale_q;
  logic              hport_q;
  logic [TIME_W-1:0] age;

  // Output register
  logic                             out_valid_q;
  logic [tpmlf_pkg::OUT_DATA_W-1:0] out_data_q;

  // Derived control
  logic              accept;
  logic              learn;
  logic              lookup;
  logic              out_free;
  logic              dec_fire;
  logic              hit;
  logic              aged;
  logic [1:0]        other;
  logic [1:0]        egress;
  logic              to_host;
  tpmlf_pkg::dec_e   decision;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign learn    = phy_q && fwd_en_q;
  assign lookup   = !group_q && (!phy_q || fwd_en_q);
  assign out_free = !out_valid_q || m_axis_tready;
  assign dec_fire = (state_q == tpmlf_pkg::ST_DEC) && out_free;
  assign wr_entry = '{addr: smac_q, port: sport_q[0], stamp: now_q};

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_en_q    <= 1'b0;
      age_limit_q <= tpmlf_pkg::AGE_LIMIT_RESET;
      ports_q     <= 2'b11;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tpmlf_pkg::CFG_FORWARDING: fwd_en_q    <= cfg_data_i[0];
        tpmlf_pkg::CFG_AGE_LIMIT:  age_limit_q <= cfg_data_i[TIME_W-1:0];
        tpmlf_pkg::CFG_PORTS:      ports_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpmlf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and input ready
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      tpmlf_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = tpmlf_pkg::ST_READ;
      end
      tpmlf_pkg::ST_READ: state_d = tpmlf_pkg::ST_EVAL;
      tpmlf_pkg::ST_EVAL: state_d = tpmlf_pkg::ST_DEC;
      tpmlf_pkg::ST_DEC: begin
        if (out_free) state_d = tpmlf_pkg::ST_IDLE;
      end
      default: state_d = tpmlf_pkg::ST_IDLE;
    endcase
  end

  // Capture the header and hash both addresses
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sport_q  <= s_axis_tdata[1:0];
      dmac_q   <= s_axis_tdata[49:2];
      smac_q   <= s_axis_tdata[97:50];
      flen_q   <= s_axis_tdata[111:98];
      now_q    <= s_axis_tdata[159:112];
      slot_d_q <= tpmlf_pkg::slot_of(s_axis_tdata[49:2]);
      slot_s_q <= tpmlf_pkg::slot_of(s_axis_tdata[97:50]);
      phy_q    <= !s_axis_tdata[1];
      group_q  <= tpmlf_pkg::is_group(s_axis_tdata[49:2]);
    end
  end

  // Table memory: learn write and destination read in the same cycle
  always_ff @(posedge clk_i) begin
    if (state_q == tpmlf_pkg::ST_READ) begin
      if (learn) mem_q[slot_s_q] <= wr_entry;
      rd_q        <= mem_q[slot_d_q];
      same_slot_q <= learn && (slot_s_q == slot_d_q);
    end
  end

  // Valid bits: set on learn, clear on an aged-out lookup
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(tpmlf_pkg::TABLE_ENTRIES); i++) valid_q[i] <= 1'b0;
    end else begin
      if ((state_q == tpmlf_pkg::ST_READ) && learn) valid_q[slot_s_q] <= 1'b1;
      if (dec_fire && aged) valid_q[slot_d_q] <= 1'b0;
    end
  end

  // Forward the entry just learned when both addresses share a slot
  assign ent = same_slot_q ? wr_entry : rd_q;
  assign age = now_q - ent.stamp;

  // Compare address and age
  always_ff @(posedge clk_i) begin
    if (state_q == tpmlf_pkg::ST_EVAL) begin
      match_q <= valid_q[slot_d_q] && (ent.addr == dmac_q);
      stale_q <= age > age_limit_q;
      hport_q <= ent.port;
    end
  end

  // Forwarding decision
  always_comb begin
    hit      = match_q && !stale_q;
    aged     = lookup && match_q && stale_q;
    other    = sport_q[0] ? 2'b01 : 2'b10;
    egress   = 2'b00;
    to_host  = 1'b0;
    decision = tpmlf_pkg::DEC_FLOOD_MCAST;
    if (phy_q) begin
      to_host = flen_q <= tpmlf_pkg::HOST_BUFFER_BYTES;
      priority if (!fwd_en_q) begin
        decision = tpmlf_pkg::DEC_FWD_OFF;
      end else if (group_q) begin
        decision = tpmlf_pkg::DEC_FLOOD_MCAST;
        egress   = other;
      end else if (!hit) begin
        decision = tpmlf_pkg::DEC_FLOOD_UNKNOWN;
        egress   = other;
      end else if (hport_q == sport_q[0]) begin
        decision = tpmlf_pkg::DEC_SAME_PORT;
      end else begin
        decision = tpmlf_pkg::DEC_KNOWN;
        egress   = hport_q ? 2'b10 : 2'b01;
      end
    end else begin
      priority if (group_q) begin
        decision = tpmlf_pkg::DEC_FLOOD_MCAST;
        egress   = 2'b11;
      end else if (!hit) begin
        decision = tpmlf_pkg::DEC_HOST_MISS;
        egress   = 2'b01;
      end else begin
        decision = tpmlf_pkg::DEC_KNOWN;
        egress   = hport_q ? 2'b10 : 2'b01;
      end
    end
  end

  // Output register: load on decision, drop valid when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dec_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_fire) begin
      out_data_q <= {aged, learn, decision, to_host, egress & ports_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A learned slot is valid when its lookup is evaluated
  a_learn_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpmlf_pkg::ST_EVAL) && learn |-> valid_q[slot_s_q])
    else $error("learned slot not valid at compare");

  // An aged-out verdict is always a miss
  a_aged_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7] |->
      (m_axis_tdata[5:3] == tpmlf_pkg::DEC_FLOOD_UNKNOWN) ||
      (m_axis_tdata[5:3] == tpmlf_pkg::DEC_HOST_MISS))
    else $error("aged-out verdict is not a miss");

  // Learning never happens with forwarding off
  a_learn_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6] |->
      (m_axis_tdata[5:3] != tpmlf_pkg::DEC_FWD_OFF) &&
      (m_axis_tdata[5:3] != tpmlf_pkg::DEC_HOST_MISS))
    else $error("learned flag on a non-learning verdict");

  // An accepted header issues no decision while it passes the read and compare states
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !dec_fire ##1 !dec_fire)
    else $error("decision issued too early");

endmodule
`default_nettype wire
